// File: rtl/pcc_pkg.sv
// pcc_pkg: shared types and constants of the pair co-occurrence counter
// holds the transfer payload structs, command codes, controller states and
// the control/status bundles between controller and datapath; no dependencies
`timescale 1ns / 1ps

package pcc_pkg;

  // fixed field widths
  localparam int CMD_W       = 2;
  localparam int ELEM_W      = 8;
  localparam int OUT_COUNT_W = 16;
  localparam int DICT_W      = 8;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // register map (word index)
  localparam logic REG_DICT_SIZE = 1'b0;
  localparam logic [DICT_W-1:0] DICT_SIZE_RESET = 8'd128;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ELEM_W-1:0] first_element;
    logic [ELEM_W-1:0] second_element;
  } in_item_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] count;
    logic                   status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_UPDATE
  } pcc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted command
    logic index;       // compute the counter address
    logic read;        // read the counter
    logic update;      // write back and load the result register
    logic clear_step;  // zero one counter of the clearing pass
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic err;
    logic clear_last;
  } dp_status_t;

endpackage

// File: rtl/pair_cooccurrence_counter_core.sv
// pair_cooccurrence_counter_core: top level of the pair co-occurrence counter
// holds the register port and joins pcc_ctrl and pcc_datapath; depends on pcc_pkg
`timescale 1ns / 1ps

// Keeps one saturating COUNT_WIDTH-bit counter per unordered pair of distinct
// elements 1..n in upper-triangle order in a single-port-write, registered-read
// memory of MAX_ELEMENTS*(MAX_ELEMENTS-1)/2 words. One command is worked at a
// time: increment and read go through accept, address multiply, memory read,
// write-back and result load; an invalid pair or unused command skips the
// memory read, and a clear runs the clearing pass, which zeroes one counter
// per cycle, before its result load. After reset the same pass runs with
// in_stall high; register writes are taken meanwhile. The result register
// lets the next command be accepted while a result still waits.
// dictionary_size sits at byte address 0.

module pair_cooccurrence_counter_core #(
  parameter int MAX_ELEMENTS = 128,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcc_pkg::out_item_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [pcc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [pcc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic [pcc_pkg::DICT_W-1:0] dict_size_r;
  logic                       reg_sel;
  pcc_pkg::ctrl_cmd_t         cmd;
  pcc_pkg::dp_status_t        status;

  // register decode: word index is the top address bit
  assign reg_sel = (paddr[pcc_pkg::APB_ADDR_W-1] == pcc_pkg::REG_DICT_SIZE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_size_r <= pcc_pkg::DICT_SIZE_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      dict_size_r <= pwdata[pcc_pkg::DICT_W-1:0];
    end
  end

  assign prdata = reg_sel ? pcc_pkg::APB_DATA_W'(dict_size_r) : '0;

  pcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pcc_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .dict_size (dict_size_r),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// File: rtl/pcc_ctrl.sv
// pcc_ctrl: controller state machine of the pair co-occurrence counter
// sequences accept, index, read-modify-write, clearing pass and result load
// depends on pcc_pkg
`timescale 1ns / 1ps

module pcc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pcc_pkg::dp_status_t status,
  output pcc_pkg::ctrl_cmd_t  cmd
);

  pcc_pkg::pcc_state_t state_r, state_nxt;
  logic reply_r, reply_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  // state, reply flag and result valid registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcc_pkg::ST_CLEAR;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reply_r     <= reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register is free when empty or being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      pcc_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = reply_r ? pcc_pkg::ST_UPDATE : pcc_pkg::ST_IDLE;
        end
      end
      pcc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = pcc_pkg::ST_INDEX;
        end
      end
      pcc_pkg::ST_INDEX: begin
        cmd.index = 1'b1;
        priority if (status.is_clear) begin
          reply_nxt = 1'b1;
          state_nxt = pcc_pkg::ST_CLEAR;
        end else if (status.err) begin
          state_nxt = pcc_pkg::ST_UPDATE;
        end else begin
          state_nxt = pcc_pkg::ST_READ;
        end
      end
      pcc_pkg::ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = pcc_pkg::ST_UPDATE;
      end
      pcc_pkg::ST_UPDATE: begin
        if (slot_free) begin
          cmd.update = 1'b1;
          state_nxt  = pcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcc_pkg::ST_IDLE;
      end
    endcase
  end

  // result valid: set on load, dropped when taken
  assign out_valid_nxt = cmd.update ? 1'b1 : (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

endmodule

// File: rtl/pcc_datapath.sv
// pcc_datapath: pair check, triangular address, counter memory and result register
// the counter memory is one write and one registered read per cycle
// depends on pcc_pkg
`timescale 1ns / 1ps

module pcc_datapath #(
  parameter int MAX_ELEMENTS = 128,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pcc_pkg::in_item_t                 in_data,
  input  logic [pcc_pkg::DICT_W-1:0]        dict_size,
  input  pcc_pkg::ctrl_cmd_t                cmd,
  output pcc_pkg::dp_status_t               status,
  output pcc_pkg::out_item_t                out_data
);

  localparam int DEPTH   = MAX_ELEMENTS * (MAX_ELEMENTS - 1) / 2;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SPAN_W  = $clog2(2 * MAX_ELEMENTS + 1);
  localparam int PROD_W  = pcc_pkg::ELEM_W + SPAN_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];

  logic [pcc_pkg::CMD_W-1:0]  cmd_r;
  logic [pcc_pkg::ELEM_W-1:0] lo_r;
  logic [pcc_pkg::ELEM_W-1:0] offset_r;
  logic                       err_r;
  logic [ADDR_W-1:0]          addr_r;
  logic [ADDR_W-1:0]          clr_addr_r;
  logic [COUNT_WIDTH-1:0]     rd_data_r;
  pcc_pkg::out_item_t         out_data_r;

  logic [pcc_pkg::ELEM_W-1:0] e1, e2, lo, hi;
  logic                       pair_bad, cmd_unused, cmd_clear;
  logic [SPAN_W-1:0]          span;
  logic [PROD_W-1:0]          prod, row_addr;
  logic                       clr_last;
  logic [COUNT_WIDTH-1:0]     cnt_new, val;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0]     wr_data;
  pcc_pkg::out_item_t         result;

  // order the pair and check it against the dictionary size
  assign e1 = in_data.first_element;
  assign e2 = in_data.second_element;
  assign lo = (e1 < e2) ? e1 : e2;
  assign hi = (e1 < e2) ? e2 : e1;
  assign pair_bad = (lo == '0) || (hi > dict_size) || (32'(hi) > MAX_ELEMENTS) || (lo == hi);
  assign cmd_clear  = (in_data.command == pcc_pkg::CMD_CLEAR);
  assign cmd_unused = (in_data.command != pcc_pkg::CMD_INC) &&
                      (in_data.command != pcc_pkg::CMD_GET) && !cmd_clear;

  // capture the accepted command
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_data.command;
      lo_r     <= lo;
      offset_r <= hi - lo - 8'd1;
      err_r    <= cmd_unused || (!cmd_clear && pair_bad);
    end
  end

  // triangular row base: (lo-1)*(2*MAX_ELEMENTS-lo)/2, plus column offset
  assign span     = SPAN_W'(2 * MAX_ELEMENTS) - SPAN_W'(lo_r);
  assign prod     = PROD_W'(lo_r - 8'd1) * PROD_W'(span);
  assign row_addr = (prod >> 1) + PROD_W'(offset_r);

  always_ff @(posedge clk) begin
    if (cmd.index) begin
      addr_r <= ADDR_W'(row_addr);
    end
  end

  // clearing pass pointer, wraps to zero after the last counter
  assign clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + 1'b1;
    end
  end

  // saturating increment
  assign cnt_new = (rd_data_r == COUNT_MAX) ? rd_data_r : rd_data_r + 1'b1;
  assign val     = (cmd_r == pcc_pkg::CMD_INC) ? cnt_new : rd_data_r;

  // single write port shared by the clearing pass and the write-back
  assign wr_en   = cmd.clear_step ||
                   (cmd.update && !err_r && (cmd_r == pcc_pkg::CMD_INC));
  assign wr_addr = cmd.clear_step ? clr_addr_r : addr_r;
  assign wr_data = cmd.clear_step ? '0 : cnt_new;

  // counter memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.read) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // result selection
  always_comb begin
    result = '0;
    priority if (err_r) begin
      result.status = pcc_pkg::STATUS_ERR;
    end else if (cmd_r == pcc_pkg::CMD_CLEAR) begin
      result.status = pcc_pkg::STATUS_OK;
    end else begin
      result.count  = pcc_pkg::OUT_COUNT_W'(32'(val));
      result.status = pcc_pkg::STATUS_OK;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_data_r <= result;
    end
  end

  assign out_data          = out_data_r;
  assign status.is_clear   = (cmd_r == pcc_pkg::CMD_CLEAR);
  assign status.err        = err_r;
  assign status.clear_last = clr_last;

endmodule

// File: rtl/pcc_checker.sv
// pcc_checker: port-level assertions for pair_cooccurrence_counter_core
// bound to the top level below; depends on pcc_pkg
`timescale 1ns / 1ps

module pcc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pcc_pkg::out_item_t out_data
);

  // a stalled result stays valid
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // one command at a time: input stalls right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while busy");

  // an error result carries a zero count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pcc_pkg::STATUS_ERR) |-> (out_data.count == '0))
    else $error("error result with nonzero count");

  // the clearing pass after reset holds off input
  a_reset_clear: assert property (@(posedge clk)
    $rose(rst_n) |-> in_stall)
    else $error("input open during reset clearing pass");

endmodule

bind pair_cooccurrence_counter_core pcc_checker u_pcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/tb_pair_cooccurrence_counter_core.sv
// tb_pair_cooccurrence_counter_core: self-checking bench for the pair counter store
// drives commands and register writes, predicts every result in-bench, and
// compares each result transfer; depends on pcc_pkg and pair_cooccurrence_counter_core
`timescale 1ns / 1ps

module tb_pair_cooccurrence_counter_core;

  localparam int MAX_ELEMENTS = 128;
  localparam int COUNT_WIDTH  = 16;
  localparam int PAIR_DEPTH   = MAX_ELEMENTS * (MAX_ELEMENTS - 1) / 2;
  localparam int IDLE_GAP     = 12;
  localparam int LONG_HOLD    = 300;

  localparam logic [pcc_pkg::CMD_W-1:0]      CMD_UNUSED     = 2'd3;
  localparam logic [pcc_pkg::APB_ADDR_W-1:0] DICT_SIZE_ADDR = {pcc_pkg::REG_DICT_SIZE, 2'b00};

  // random phases: dictionary size and number of commands
  localparam int PHASE_COUNT = 9;
  localparam int PHASE_DICT  [PHASE_COUNT] = '{5, 2, 128, 12, 255, 0, 1, 40, 7};
  localparam int PHASE_ITEMS [PHASE_COUNT] = '{200, 80, 220, 200, 120, 30, 30, 150, 120};

  typedef struct packed {
    pcc_pkg::in_item_t  item;
    logic               typed;
    pcc_pkg::out_item_t result;
  } directed_row_t;

  // directed commands; typed rows carry their result, the rest use the predictor
  localparam int DIRECTED_COUNT = 23;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{'{pcc_pkg::CMD_GET,   8'd1,   8'd2},   1'b1, '{16'd0, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_INC,   8'd1,   8'd2},   1'b1, '{16'd1, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_INC,   8'd2,   8'd1},   1'b1, '{16'd2, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_GET,   8'd128, 8'd127}, 1'b1, '{16'd0, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_INC,   8'd127, 8'd128}, 1'b1, '{16'd1, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_INC,   8'd128, 8'd1},   1'b1, '{16'd1, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_GET,   8'd1,   8'd128}, 1'b1, '{16'd1, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_GET,   8'd0,   8'd5},   1'b1, '{16'd0, pcc_pkg::STATUS_ERR}},
    '{'{pcc_pkg::CMD_GET,   8'd5,   8'd0},   1'b1, '{16'd0, pcc_pkg::STATUS_ERR}},
    '{'{pcc_pkg::CMD_INC,   8'd7,   8'd7},   1'b1, '{16'd0, pcc_pkg::STATUS_ERR}},
    '{'{pcc_pkg::CMD_INC,   8'd129, 8'd1},   1'b1, '{16'd0, pcc_pkg::STATUS_ERR}},
    '{'{pcc_pkg::CMD_GET,   8'd255, 8'd255}, 1'b1, '{16'd0, pcc_pkg::STATUS_ERR}},
    '{'{pcc_pkg::CMD_INC,   8'd0,   8'd0},   1'b1, '{16'd0, pcc_pkg::STATUS_ERR}},
    '{'{CMD_UNUSED,         8'd1,   8'd2},   1'b1, '{16'd0, pcc_pkg::STATUS_ERR}},
    '{'{CMD_UNUSED,         8'd255, 8'd128}, 1'b1, '{16'd0, pcc_pkg::STATUS_ERR}},
    '{'{pcc_pkg::CMD_INC,   8'd64,  8'd65},  1'b0, '{16'd0, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_INC,   8'd65,  8'd64},  1'b0, '{16'd0, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_GET,   8'd64,  8'd65},  1'b0, '{16'd0, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_CLEAR, 8'd0,   8'd0},   1'b1, '{16'd0, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_GET,   8'd1,   8'd2},   1'b1, '{16'd0, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_GET,   8'd127, 8'd128}, 1'b1, '{16'd0, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_CLEAR, 8'd255, 8'd255}, 1'b1, '{16'd0, pcc_pkg::STATUS_OK}},
    '{'{pcc_pkg::CMD_INC,   8'd2,   8'd1},   1'b1, '{16'd1, pcc_pkg::STATUS_OK}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pcc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pcc_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pcc_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [pcc_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [pcc_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  // predictor state
  logic [COUNT_WIDTH-1:0]     pair_count [PAIR_DEPTH];
  logic [pcc_pkg::DICT_W-1:0] dict_size;
  pcc_pkg::out_item_t         pending_pair_results [$];

  int  error_count = 0;
  int  burst_left = 0;
  int  rx_left = 0;
  int  hold_left = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  long_hold_req = 1'b0;
  pcc_pkg::out_item_t oldest_result;

  pair_cooccurrence_counter_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // hard stop for a hung run
  initial begin
    #36_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // next state of the counter store and the result of one command
  function automatic pcc_pkg::out_item_t predict_pair_result(input pcc_pkg::in_item_t item);
    pcc_pkg::out_item_t res;
    int n_eff;
    int lo;
    int hi;
    int slot;
    res.count = '0;
    res.status = pcc_pkg::STATUS_OK;
    n_eff = (dict_size > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(dict_size);
    if (item.command == pcc_pkg::CMD_CLEAR) begin
      foreach (pair_count[i]) pair_count[i] = '0;
      return res;
    end
    if (item.command != pcc_pkg::CMD_INC && item.command != pcc_pkg::CMD_GET) begin
      res.status = pcc_pkg::STATUS_ERR;
      return res;
    end
    lo = (item.first_element < item.second_element) ? item.first_element : item.second_element;
    hi = (item.first_element < item.second_element) ? item.second_element : item.first_element;
    if (lo == 0 || hi > n_eff || lo == hi) begin
      res.status = pcc_pkg::STATUS_ERR;
      return res;
    end
    // upper-triangle slot, independent of the dictionary size
    slot = (lo - 1) * (2 * MAX_ELEMENTS - lo) / 2 + (hi - lo - 1);
    if (item.command == pcc_pkg::CMD_INC && pair_count[slot] != '1)
      pair_count[slot] = pair_count[slot] + 1'b1;
    res.count = pair_count[slot];
    return res;
  endfunction

  // mostly well-formed pairs, plus noise, unused commands and rare clears
  function automatic pcc_pkg::in_item_t random_command(input int n_eff);
    pcc_pkg::in_item_t item;
    int pick;
    pick = $urandom_range(0, 99);
    item.first_element  = 8'($urandom_range(0, 255));
    item.second_element = 8'($urandom_range(0, 255));
    if (pick == 0) begin
      item.command = pcc_pkg::CMD_CLEAR;
    end else if (pick < 4) begin
      item.command = CMD_UNUSED;
    end else begin
      item.command = (pick < 70) ? pcc_pkg::CMD_INC : pcc_pkg::CMD_GET;
      if (pick >= 10 && n_eff >= 2) begin
        item.first_element = 8'($urandom_range(1, n_eff));
        do item.second_element = 8'($urandom_range(1, n_eff));
        while (item.second_element == item.first_element);
      end
    end
    return item;
  endfunction

  // offer one command in bursts with random gaps, record its result on transfer
  task automatic offer_command(input pcc_pkg::in_item_t item, input bit typed,
                               input pcc_pkg::out_item_t typed_result);
    pcc_pkg::out_item_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (tx_idle_on) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_pair_result(item);
    pending_pair_results.push_back(typed ? typed_result : predicted);
  endtask

  // let every outstanding result arrive before touching the register
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_pair_results.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic write_dict_size(input logic [pcc_pkg::DICT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DICT_SIZE_ADDR;
    pwdata  <= pcc_pkg::APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    dict_size = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== pcc_pkg::APB_DATA_W'(value)) begin
      $display("%0t: dictionary_size read back, expected %0d, actual %0d",
               $time, value, prdata);
      error_count++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: own stall pattern, plus one long hold on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left--;
    end else if (out_stall || !rx_idle_on) begin
      out_stall <= 1'b0;
      rx_left = $urandom_range(1, 8);
    end else begin
      out_stall <= 1'b1;
      rx_left = $urandom_range(0, 4);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pair_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual count %0d status %0d",
                 $time, out_data.count, out_data.status);
        error_count++;
      end else begin
        oldest_result = pending_pair_results.pop_front();
        if (out_data.count !== oldest_result.count) begin
          $display("%0t: count mismatch, expected %0d, actual %0d",
                   $time, oldest_result.count, out_data.count);
          error_count++;
        end
        if (out_data.status !== oldest_result.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, oldest_result.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    int n_eff;
    foreach (pair_count[i]) pair_count[i] = '0;
    dict_size = pcc_pkg::DICT_SIZE_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // register is taken during the clearing pass after reset
    write_dict_size(8'd128);

    // directed commands at full size
    for (int r = 0; r < DIRECTED_COUNT; r++)
      offer_command(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
    wait_idle();

    // random phases over several dictionary sizes
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_dict_size(8'(PHASE_DICT[p]));
      n_eff = (PHASE_DICT[p] > MAX_ELEMENTS) ? MAX_ELEMENTS : PHASE_DICT[p];
      tx_idle_on = (p != 3);
      rx_idle_on = (p != 1 && p != 7);
      if (p == 2) long_hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS[p]; k++)
        offer_command(random_command(n_eff), 1'b0, '0);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
